// File: src/dual_channel_moving_average_defines.svh
// Assertion macros for the dual-channel moving average.
// Used by the top level only; needs a clock and an active-low reset name.
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication
`define DCMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dcma_pkg.sv
// Shared types and constants for the dual-channel moving average.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package dcma_pkg;

	localparam int WINDOW    = 8;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = 16 + $clog2(WINDOW) + 1;
	localparam int DIV_STEPS = (SUM_W + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	typedef logic signed [15:0] level_t;
	typedef logic signed [10:0] delta_t;
	typedef logic [14:0]        mstart_t;
	typedef logic signed [16:0] wide_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [SUM_W-1:0]   mag_t;

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic {
		REG_MOIST_START = 1'b0,
		REG_TEMP_START  = 1'b1
	} reg_idx_t;

	localparam wide_t  MOIST_LO      = 17'sd1280;
	localparam wide_t  MOIST_HI      = 17'sd24320;
	localparam wide_t  TEMP_MIN      = -17'sd32768;
	localparam wide_t  TEMP_MAX      = 17'sd32767;
	localparam level_t MOIST_FLAG_HI = 16'sd25600;
	localparam level_t TEMP_FLAG_LO  = -16'sd5120;
	localparam level_t TEMP_FLAG_HI  = 16'sd20480;

	localparam mstart_t MOIST_START_RST = 15'd12800;
	localparam level_t  TEMP_START_RST  = 16'sd6400;

endpackage

`default_nettype wire

// File: src/dcma_in_if.sv
// Sample channel: valid/ready handshake with operation and two deltas.
// Depends on dcma_pkg.
`default_nettype none

interface dcma_in_if;
	import dcma_pkg::*;

	logic   valid;
	logic   ready;
	op_t    operation;
	delta_t moisture_delta;
	delta_t temperature_delta;

	modport source (output valid, operation, moisture_delta, temperature_delta, input ready);
	modport sink   (input valid, operation, moisture_delta, temperature_delta, output ready);
endinterface

`default_nettype wire

// File: src/dcma_out_if.sv
// Result channel: valid/ready handshake with two means and a range flag.
// Depends on dcma_pkg.
`default_nettype none

interface dcma_out_if;
	import dcma_pkg::*;

	logic    valid;
	logic    ready;
	mstart_t moisture_mean;
	level_t  temperature_mean;
	logic    out_of_range;

	modport source (output valid, moisture_mean, temperature_mean, out_of_range, input ready);
	modport sink   (input valid, moisture_mean, temperature_mean, out_of_range, output ready);
endinterface

`default_nettype wire

// File: src/dual_channel_moving_average.sv
// Channel   Dir  Handshake          Payload
// samples   in   valid/ready        operation, moisture_delta, temperature_delta
// results   out  valid/ready        moisture_mean, temperature_mean, out_of_range
// apb       cfg  psel/penable       moisture_start @0x0, temperature_start @0x4
//
// Restart: 1 cycle. Sample: result valid WINDOW + DIV_STEPS + 3 cycles after the transfer
// (21 for WINDOW = 8), next transfer taken one cycle later (22-cycle period): one full
// rotation of the cell row, a divider load cycle, DIV_STEPS + 1 divider cycles, one output cycle.
// Reset is asynchronous; levels and start registers take their reset values.
// A finished result sits in the output register; a new transfer is taken meanwhile,
// and the next result waits until the output register is free.
// Depends on dcma_pkg, dcma_in_if, dcma_out_if, dcma_cell, dcma_divider and the defines.
`default_nettype none
`include "dual_channel_moving_average_defines.svh"

module dual_channel_moving_average (
	input  wire                            clk,
	input  wire                            arst_n,
	dcma_in_if.sink                        samples,
	dcma_out_if.source                     results,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [dcma_pkg::ADDR_W-1:0]     paddr,
	input  wire [dcma_pkg::DATA_W-1:0]     pwdata,
	output logic [dcma_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import dcma_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIVL,
		ST_DIVW,
		ST_DONE
	} state_t;

	state_t          state_q;
	cnt_t            rot_q;
	cnt_t            filled_q;
	mstart_t         moisture_start_q;
	level_t          temperature_start_q;
	level_t          moisture_level_q;
	level_t          temperature_level_q;
	logic signed [SUM_W-1:0] m_acc_q;
	logic signed [SUM_W-1:0] t_acc_q;
	logic            m_neg_q;
	logic            t_neg_q;
	logic            out_valid_q;
	mstart_t         out_m_q;
	level_t          out_t_q;
	logic            out_flag_q;

	level_t          m_chain [WINDOW+1];
	level_t          t_chain [WINDOW+1];
	level_t          m_tail;
	level_t          t_tail;

	logic            in_fire;
	logic            sample_fire;
	logic            restart_fire;
	logic            shift_en;
	logic            cfg_write;
	logic            tail_filled;
	wide_t           m_sum;
	wide_t           t_sum;
	level_t          m_new;
	level_t          t_new;
	logic            div_start;
	mag_t            m_mag;
	mag_t            t_mag;
	logic            m_busy;
	logic            t_busy;
	mag_t            m_quo;
	mag_t            t_quo;
	level_t          m_mean;
	level_t          t_mean;
	logic            flag;
	logic            out_free;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_MOIST_START: prdata = DATA_W'(moisture_start_q);
			REG_TEMP_START:  prdata = DATA_W'(temperature_start_q);
			default:         prdata = '0;
		endcase
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	assign sample_fire   = in_fire && (samples.operation == OP_SAMPLE);
	assign restart_fire  = in_fire && (samples.operation == OP_RESTART);

	// level update with clamp / saturation
	always_comb begin
		m_sum = 17'(moisture_level_q) + 17'(samples.moisture_delta);
		t_sum = 17'(temperature_level_q) + 17'(samples.temperature_delta);
		priority if (m_sum < MOIST_LO) begin
			m_new = 16'(MOIST_LO);
		end else if (m_sum > MOIST_HI) begin
			m_new = 16'(MOIST_HI);
		end else begin
			m_new = m_sum[15:0];
		end
		priority if (t_sum < TEMP_MIN) begin
			t_new = 16'(TEMP_MIN);
		end else if (t_sum > TEMP_MAX) begin
			t_new = 16'(TEMP_MAX);
		end else begin
			t_new = t_sum[15:0];
		end
	end

	// cell row: insert at head on a sample, rotate tail to head while summing
	assign shift_en   = sample_fire || (state_q == ST_SUM);
	assign m_tail     = m_chain[WINDOW];
	assign t_tail     = t_chain[WINDOW];
	assign m_chain[0] = (state_q == ST_SUM) ? m_tail : m_new;
	assign t_chain[0] = (state_q == ST_SUM) ? t_tail : t_new;

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		dcma_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.m_in     (m_chain[k]),
			.t_in     (t_chain[k]),
			.m_out    (m_chain[k+1]),
			.t_out    (t_chain[k+1])
		);
	end

	// tail at rotation step j is cell WINDOW-1-j, filled when j >= WINDOW - filled
	assign tail_filled = ({1'b0, rot_q} + {1'b0, filled_q}) >= (CNT_W+1)'(WINDOW);

	assign div_start = (state_q == ST_DIVL);
	assign m_mag     = m_acc_q[SUM_W-1] ? mag_t'(-m_acc_q) : mag_t'(m_acc_q);
	assign t_mag     = t_acc_q[SUM_W-1] ? mag_t'(-t_acc_q) : mag_t'(t_acc_q);

	dcma_divider u_m_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (m_mag),
		.divisor  (filled_q),
		.busy     (m_busy),
		.quotient (m_quo)
	);

	dcma_divider u_t_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_mag),
		.divisor  (filled_q),
		.busy     (t_busy),
		.quotient (t_quo)
	);

	assign m_mean = m_neg_q ? -m_quo[15:0] : m_quo[15:0];
	assign t_mean = t_neg_q ? -t_quo[15:0] : t_quo[15:0];
	assign flag   = (m_mean < 16'sd0) || (m_mean > MOIST_FLAG_HI) ||
	                (t_mean < TEMP_FLAG_LO) || (t_mean > TEMP_FLAG_HI);
	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			rot_q               <= '0;
			filled_q            <= '0;
			moisture_start_q    <= MOIST_START_RST;
			temperature_start_q <= TEMP_START_RST;
			moisture_level_q    <= 16'(MOIST_START_RST);
			temperature_level_q <= TEMP_START_RST;
			out_valid_q         <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_MOIST_START: moisture_start_q    <= pwdata[14:0];
					REG_TEMP_START:  temperature_start_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && results.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (restart_fire) begin
						moisture_level_q    <= 16'(moisture_start_q);
						temperature_level_q <= temperature_start_q;
						filled_q            <= '0;
					end else if (sample_fire) begin
						moisture_level_q    <= m_new;
						temperature_level_q <= t_new;
						if (filled_q != CNT_W'(WINDOW)) begin
							filled_q <= filled_q + 1'b1;
						end
						rot_q   <= '0;
						m_acc_q <= '0;
						t_acc_q <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (tail_filled) begin
						m_acc_q <= m_acc_q + SUM_W'(m_tail);
						t_acc_q <= t_acc_q + SUM_W'(t_tail);
					end
					rot_q <= rot_q + 1'b1;
					if (rot_q == CNT_W'(WINDOW - 1)) begin
						state_q <= ST_DIVL;
					end
				end
				ST_DIVL: begin
					m_neg_q <= m_acc_q[SUM_W-1];
					t_neg_q <= t_acc_q[SUM_W-1];
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!m_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_m_q     <= m_mean[14:0];
						out_t_q     <= t_mean;
						out_flag_q  <= flag;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (out_valid_q && results.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid            = out_valid_q;
	assign results.moisture_mean    = out_m_q;
	assign results.temperature_mean = out_t_q;
	assign results.out_of_range     = out_flag_q;

	`DCMA_ASSERT_NEXT(a_sample_sums, clk, arst_n, sample_fire, state_q == ST_SUM, "sample transfer did not start the window sum")
	`DCMA_ASSERT_NEXT(a_restart_reload, clk, arst_n, restart_fire, (filled_q == '0) && (moisture_level_q == 16'($past(moisture_start_q))), "restart did not reload the moisture level and empty the window")
	`DCMA_ASSERT_NOW(a_div_lockstep, clk, arst_n, state_q == ST_DIVW, m_busy == t_busy, "channel dividers out of step")
	`DCMA_ASSERT_NOW(a_filled_bound, clk, arst_n, state_q != ST_IDLE, (filled_q != '0) && (filled_q <= CNT_W'(WINDOW)), "fill count out of bounds while working")
endmodule

`default_nettype wire

// File: src/dcma_cell.sv
// One window cell: holds a moisture and a temperature entry, shifts to its neighbor.
// Depends on dcma_pkg.
`default_nettype none

module dcma_cell (
	input  wire             clk,
	input  wire             shift_en,
	input  dcma_pkg::level_t m_in,
	input  dcma_pkg::level_t t_in,
	output dcma_pkg::level_t m_out,
	output dcma_pkg::level_t t_out
);
	import dcma_pkg::*;

	level_t m_q;
	level_t t_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			m_q <= m_in;
			t_q <= t_in;
		end
	end

	assign m_out = m_q;
	assign t_out = t_q;
endmodule

`default_nettype wire

// File: src/dcma_divider.sv
// Radix-4 restoring divider: unsigned window sum by fill count, two bits a cycle.
// Depends on dcma_pkg.
`default_nettype none

module dcma_divider (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  dcma_pkg::mag_t dividend,
	input  dcma_pkg::cnt_t divisor,
	output logic           busy,
	output dcma_pkg::mag_t quotient
);
	import dcma_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	cnt_t              divisor_q;
	logic [DIV_W-1:0]  quo_d;
	logic [CNT_W-1:0]  rem_d;

	always_comb begin
		logic [CNT_W:0] tmp;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < 2; i++) begin
			tmp   = {rem_d, quo_d[DIV_W-1]};
			quo_d = {quo_d[DIV_W-2:0], 1'b0};
			if (tmp >= {1'b0, divisor_q}) begin
				tmp      = tmp - {1'b0, divisor_q};
				quo_d[0] = 1'b1;
			end
			rem_d = tmp[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= DIV_W'(dividend);
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[SUM_W-1:0];
endmodule

`default_nettype wire

// File: verif/tb_dual_channel_moving_average.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_channel_moving_average: a scoreboard class predicts
// the windowed means and range flag per sample transfer; tasks drive APB and streams.
// Depends on dcma_pkg, dcma_in_if, dcma_out_if and the block itself.

import dcma_pkg::*;

typedef struct packed {
	mstart_t moisture_mean;
	level_t  temperature_mean;
	logic    out_of_range;
} mean_result_t;

class moving_average_scoreboard;
	int moist_start;
	int temp_start;
	int moist_level;
	int temp_level;
	int moist_win[WINDOW];
	int temp_win[WINDOW];
	int slot;
	int filled;
	mean_result_t pending_means[$];
	int errors;
	int sample_count;
	int restart_count;
	int checked;
	int flagged;
	int clamped;

	function new();
		moist_start = int'(MOIST_START_RST);
		temp_start  = int'(TEMP_START_RST);
		restart_levels();
	endfunction

	function void restart_levels();
		moist_level = moist_start;
		temp_level  = temp_start;
		slot        = 0;
		filled      = 0;
	endfunction

	function void set_start(reg_idx_t idx, logic [31:0] value);
		level_t tv;
		tv = value[15:0];
		if (idx == REG_MOIST_START)
			moist_start = int'(value[14:0]);
		else
			temp_start = int'(tv);
	endfunction

	function int pending();
		return pending_means.size();
	endfunction

	function void note_sample(op_t op, delta_t md, delta_t td);
		int m;
		int t;
		int msum;
		int tsum;
		int mmean;
		int tmean;
		mean_result_t want;
		if (op == OP_RESTART) begin
			restart_count++;
			restart_levels();
			return;
		end
		sample_count++;
		m = moist_level + int'(md);
		if (m < MOIST_LO || m > MOIST_HI)
			clamped++;
		if (m < MOIST_LO)
			m = MOIST_LO;
		if (m > MOIST_HI)
			m = MOIST_HI;
		moist_level = m;
		t = temp_level + int'(td);
		if (t < TEMP_MIN)
			t = TEMP_MIN;
		if (t > TEMP_MAX)
			t = TEMP_MAX;
		temp_level = t;
		moist_win[slot] = m;
		temp_win[slot]  = t;
		slot = (slot + 1) % WINDOW;
		if (filled < WINDOW)
			filled++;
		msum = 0;
		tsum = 0;
		for (int i = 0; i < filled; i++) begin
			msum += moist_win[i];
			tsum += temp_win[i];
		end
		mmean = msum / filled;
		tmean = tsum / filled;
		want.moisture_mean    = mstart_t'(mmean);
		want.temperature_mean = level_t'(tmean);
		want.out_of_range     = (mmean < 0 || mmean > MOIST_FLAG_HI ||
			tmean < TEMP_FLAG_LO || tmean > TEMP_FLAG_HI);
		if (want.out_of_range)
			flagged++;
		pending_means.push_back(want);
	endfunction

	function void check_means(mstart_t mm, level_t tm, logic flag);
		mean_result_t want;
		if (pending_means.size() == 0) begin
			$error("result transfer with no pending expectation");
			errors++;
			return;
		end
		want = pending_means.pop_front();
		checked++;
		if (mm !== want.moisture_mean) begin
			$error("moisture_mean: expected %0d, actual %0d", want.moisture_mean, mm);
			errors++;
		end
		if (tm !== want.temperature_mean) begin
			$error("temperature_mean: expected %0d, actual %0d",
				want.temperature_mean, tm);
			errors++;
		end
		if (flag !== want.out_of_range) begin
			$error("out_of_range: expected %0d, actual %0d", want.out_of_range, flag);
			errors++;
		end
	endfunction
endclass

module tb_dual_channel_moving_average;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int send_idle;
	int recv_idle;
	int settings;

	moving_average_scoreboard sb;

	dcma_in_if  samples_if ();
	dcma_out_if results_if ();

	dual_channel_moving_average u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_means(results_if.moisture_mean, results_if.temperature_mean,
				results_if.out_of_range);
		results_if.ready <= (int'($urandom_range(0, 99)) >= recv_idle);
	end

	task automatic send_item(op_t op, delta_t md, delta_t td);
		if (int'($urandom_range(0, 99)) < send_idle) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
			while (int'($urandom_range(0, 99)) < send_idle)
				@(posedge clk);
		end
		samples_if.valid             <= 1'b1;
		samples_if.operation         <= op;
		samples_if.moisture_delta    <= md;
		samples_if.temperature_delta <= td;
		do
			@(posedge clk);
		while (!samples_if.ready);
		sb.note_sample(op, md, td);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_start(idx, value);
		@(posedge clk);
	endtask

	// let the stream drain and the block go idle before touching registers
	task automatic wait_idle();
		int n;
		n = 0;
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_starts(logic [14:0] ms, logic [15:0] ts);
		wait_idle();
		apb_write(REG_MOIST_START, {17'($urandom), ms});
		apb_write(REG_TEMP_START, {16'($urandom), ts});
		settings++;
	endtask

	function automatic logic [14:0] pick_moist_start();
		case ($urandom_range(0, 4))
			0: return 15'd0;
			1: return 15'h7fff;
			2: return 15'(MOIST_LO);
			3: return 15'(MOIST_HI);
			default: return 15'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_temp_start();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(TEMP_FLAG_LO);
			3: return 16'(TEMP_FLAG_HI);
			default: return 16'($urandom);
		endcase
	endfunction

	// trend pushes a level toward its limits over a run of samples
	function automatic delta_t pick_delta(int trend);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(0, 1) ? delta_t'(1023) : delta_t'(-1024);
		if (r < 35)
			return delta_t'(int'($urandom_range(0, 127)) - 64);
		if (trend > 0)
			return delta_t'($urandom_range(0, 1023));
		if (trend < 0)
			return delta_t'(-int'($urandom_range(1, 1024)));
		return delta_t'($urandom);
	endfunction

	task automatic run_random(int count);
		int m_trend;
		int t_trend;
		m_trend = int'($urandom_range(0, 2)) - 1;
		t_trend = int'($urandom_range(0, 2)) - 1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 3) begin
				m_trend = int'($urandom_range(0, 2)) - 1;
				t_trend = int'($urandom_range(0, 2)) - 1;
				send_item(OP_RESTART, delta_t'($urandom), delta_t'($urandom));
			end else begin
				send_item(OP_SAMPLE, pick_delta(m_trend), pick_delta(t_trend));
			end
		end
	endtask

	initial begin
		sb                           = new();
		arst_n                       = 1'b0;
		psel                         = 1'b0;
		penable                      = 1'b0;
		pwrite                       = 1'b0;
		paddr                        = '0;
		pwdata                       = '0;
		samples_if.valid             = 1'b0;
		samples_if.operation         = OP_SAMPLE;
		samples_if.moisture_delta    = '0;
		samples_if.temperature_delta = '0;
		results_if.ready             = 1'b0;
		send_idle                    = 29;
		recv_idle                    = 57;
		settings                     = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset levels, field extremes, restart, window wrap
		send_item(OP_SAMPLE, delta_t'(0), delta_t'(0));
		send_item(OP_SAMPLE, delta_t'(1023), delta_t'(1023));
		send_item(OP_SAMPLE, delta_t'(-1024), delta_t'(-1024));
		send_item(OP_RESTART, delta_t'($urandom), delta_t'($urandom));
		for (int i = 0; i < 10; i++)
			send_item(OP_SAMPLE, (i % 2) ? delta_t'(-1024) : delta_t'(1023),
				(i % 2) ? delta_t'(1023) : delta_t'(-1024));

		// start levels above the clamp and at the positive limit
		set_starts(15'h7fff, 16'h7fff);
		send_item(OP_RESTART, delta_t'(0), delta_t'(0));
		send_item(OP_SAMPLE, delta_t'(1023), delta_t'(1023));
		send_item(OP_SAMPLE, delta_t'(0), delta_t'(-1024));

		// start levels below the clamp and at the negative limit
		set_starts(15'd0, 16'h8000);
		send_item(OP_RESTART, delta_t'(0), delta_t'(0));
		send_item(OP_SAMPLE, delta_t'(-1024), delta_t'(-1024));
		send_item(OP_SAMPLE, delta_t'(1023), delta_t'(0));

		set_starts(pick_moist_start(), pick_temp_start());
		send_item(OP_RESTART, delta_t'($urandom), delta_t'($urandom));
		run_random(160);

		send_idle = 57;
		recv_idle = 29;
		set_starts(pick_moist_start(), pick_temp_start());
		send_item(OP_RESTART, delta_t'($urandom), delta_t'($urandom));
		run_random(160);

		send_idle = 0;
		recv_idle = 0;
		set_starts(pick_moist_start(), pick_temp_start());
		send_item(OP_RESTART, delta_t'($urandom), delta_t'($urandom));
		run_random(160);

		wait_idle();
		$display("Stimulus: %0d sample and %0d restart transfers over %0d start settings",
			sb.sample_count, sb.restart_count, settings);
		$display("Checked %0d results: %0d flagged, %0d with moisture clamped",
			sb.checked, sb.flagged, sb.clamped);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
